// File: design/bech_pkg.sv
`timescale 1ns / 1ps
package bech_pkg;

    // Item kinds carried on the input tuser.
    typedef enum logic [1:0] {
        CMD_HRP    = 2'd0,
        CMD_DATA   = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_BAD_HRP        = 3'd1,
        ST_BAD_DATA       = 3'd2,
        ST_TOO_LONG       = 3'd3,
        ST_HRP_AFTER_DATA = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ERR,
        S_HRP,
        S_SEP_INIT,
        S_WALK_RD,
        S_WALK_FOLD,
        S_SEP,
        S_DATA,
        S_FIN_STEP,
        S_FIN_OUT
    } t_state;

    typedef enum logic [2:0] {
        SUM_HOLD,
        SUM_STEP,
        SUM_STEP_ONE,
        SUM_HRP,
        SUM_DATA,
        SUM_FOLD,
        SUM_SHIFT
    } t_sum_op;

    typedef enum logic [2:0] {
        OUT_ERR,
        OUT_ECHO,
        OUT_SEP,
        OUT_DATA,
        OUT_SUM
    } t_out_sel;

    typedef struct packed {
        logic     latch_in;
        logic     clear;
        logic     hrp_write;
        logic     walk_start;
        logic     walk_rd;
        logic     set_data_phase;
        logic     data_inc;
        logic     step_clr;
        logic     step_inc;
        logic     out_load;
        t_out_sel out_sel;
        t_sum_op  sum_op;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd    item_cmd;
        t_status item_status;
        logic    data_phase;
        logic    walk_done;
        logic    step_last;
        logic    out_free;
    } t_dp_stat;

    localparam logic [29:0] GEN0 = 30'h3b6a57b2;
    localparam logic [29:0] GEN1 = 30'h26508e6d;
    localparam logic [29:0] GEN2 = 30'h1ea119fa;
    localparam logic [29:0] GEN3 = 30'h3d4233dd;
    localparam logic [29:0] GEN4 = 30'h2a1462b3;

    localparam logic [29:0] SUM_INIT     = 30'd1;
    localparam logic [6:0]  SEPARATOR    = 7'h31;
    localparam logic [6:0]  CHAR_MIN     = 7'd33;
    localparam logic [6:0]  CHAR_MAX     = 7'd126;
    localparam logic [6:0]  UPPER_FIRST  = 7'h41;
    localparam logic [6:0]  UPPER_LAST   = 7'h5a;
    localparam logic [6:0]  DATA_MAX     = 7'd31;
    localparam int          LEN_LIMIT    = 90;
    localparam int          LEN_OVERHEAD = 7;
    localparam logic [2:0]  SUM_LAST_STEP = 3'd5;

    function automatic logic [29:0] poly_step(input logic [29:0] c);
        logic [4:0]  top;
        logic [29:0] r;
        top = c[29:25];
        r   = {c[24:0], 5'b0};
        if (top[0]) r = r ^ GEN0;
        if (top[1]) r = r ^ GEN1;
        if (top[2]) r = r ^ GEN2;
        if (top[3]) r = r ^ GEN3;
        if (top[4]) r = r ^ GEN4;
        return r;
    endfunction

    function automatic logic [6:0] alphabet(input logic [4:0] sym);
        logic [6:0] ch;
        unique case (sym)
            5'd0:  ch = 7'h71; // q
            5'd1:  ch = 7'h70; // p
            5'd2:  ch = 7'h7a; // z
            5'd3:  ch = 7'h72; // r
            5'd4:  ch = 7'h79; // y
            5'd5:  ch = 7'h39; // 9
            5'd6:  ch = 7'h78; // x
            5'd7:  ch = 7'h38; // 8
            5'd8:  ch = 7'h67; // g
            5'd9:  ch = 7'h66; // f
            5'd10: ch = 7'h32; // 2
            5'd11: ch = 7'h74; // t
            5'd12: ch = 7'h76; // v
            5'd13: ch = 7'h64; // d
            5'd14: ch = 7'h77; // w
            5'd15: ch = 7'h30; // 0
            5'd16: ch = 7'h73; // s
            5'd17: ch = 7'h33; // 3
            5'd18: ch = 7'h6a; // j
            5'd19: ch = 7'h6e; // n
            5'd20: ch = 7'h35; // 5
            5'd21: ch = 7'h34; // 4
            5'd22: ch = 7'h6b; // k
            5'd23: ch = 7'h68; // h
            5'd24: ch = 7'h63; // c
            5'd25: ch = 7'h65; // e
            5'd26: ch = 7'h36; // 6
            5'd27: ch = 7'h6d; // m
            5'd28: ch = 7'h75; // u
            5'd29: ch = 7'h61; // a
            5'd30: ch = 7'h37; // 7
            default: ch = 7'h6c; // l
        endcase
        return ch;
    endfunction

    function automatic t_status item_check(
        input t_cmd       cmd,
        input logic [6:0] v,
        input logic       data_phase,
        input logic       hrp_full,
        input logic       data_full,
        input logic       too_long
    );
        t_status st;
        st = ST_OK;
        unique case (cmd)
            CMD_HRP: begin
                if (data_phase) begin
                    st = ST_HRP_AFTER_DATA;
                end else if (v < CHAR_MIN || v > CHAR_MAX ||
                             (v >= UPPER_FIRST && v <= UPPER_LAST)) begin
                    st = ST_BAD_HRP;
                end else if (hrp_full) begin
                    st = ST_TOO_LONG;
                end
            end
            CMD_DATA: begin
                if (v > DATA_MAX) begin
                    st = ST_BAD_DATA;
                end else if (data_full) begin
                    st = ST_TOO_LONG;
                end
            end
            CMD_FINISH: begin
                if (too_long) st = ST_TOO_LONG;
            end
            CMD_NONE: st = ST_OK;
        endcase
        return st;
    endfunction

endpackage

// File: design/bech32_string_encoder_unit.sv
`timescale 1ns / 1ps
// Bech32 string encoder. Send hrp characters (tuser 0), then 5-bit data values
// (tuser 1), then a finish item (tuser 2); the block streams out the string
// characters with the checksum, tlast on the final one. Any error gives one
// result with character 0, tlast set and the status code in tuser, and starts
// a new string. One item is worked on at a time: an hrp character or a data
// value is decoded, has its result loaded once the output register is free,
// and only then does the block take the next item. The first data value or
// the finish of a string without data also walks the stored hrp through the
// buffer's single read port, a read and a fold per stored character, before
// the separator. Finish takes six checksum steps and then loads the six
// checksum characters one by one. Results wait in an output register, so a
// stalled consumer only holds the block once the next result is ready.
module bech32_string_encoder_unit #(
    parameter int MAX_HRP  = 128,
    parameter int MAX_DATA = 2047
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,  // lightning_mode
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [6:0] value
    input  logic [1:0] s_axis_tuser,   // [1:0] command
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] character
    output logic       m_axis_tlast,
    output logic [2:0] m_axis_tuser    // [2:0] status
);
    import bech_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_stat   dp_stat;
    logic [6:0] out_char;

    bech_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_in_ready (s_axis_tready)
    );

    bech_dp #(
        .MAX_HRP  (MAX_HRP),
        .MAX_DATA (MAX_DATA)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_in_valid    (s_axis_tvalid),
        .i_in_cmd      (s_axis_tuser),
        .i_in_value    (s_axis_tdata[6:0]),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_char    (out_char),
        .o_out_last    (m_axis_tlast),
        .o_out_status  (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, out_char};

endmodule

// File: design/bech_ctrl.sv
`timescale 1ns / 1ps
module bech_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  bech_pkg::t_dp_stat i_stat,
    output bech_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_ready
);
    import bech_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_stat.item_cmd == CMD_NONE) begin
                    n_state = S_IDLE;
                end else if (i_stat.item_status != ST_OK) begin
                    n_state = S_ERR;
                end else if (i_stat.item_cmd == CMD_HRP) begin
                    n_state = S_HRP;
                end else if (!i_stat.data_phase) begin
                    n_state = S_SEP_INIT;
                end else if (i_stat.item_cmd == CMD_DATA) begin
                    n_state = S_DATA;
                end else begin
                    n_state = S_FIN_STEP;
                end
            end
            S_ERR, S_HRP, S_DATA: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_SEP_INIT:  n_state = S_WALK_RD;
            S_WALK_RD: begin
                if (i_stat.walk_done) n_state = S_SEP;
                else n_state = S_WALK_FOLD;
            end
            S_WALK_FOLD: n_state = S_WALK_RD;
            S_SEP: begin
                if (i_stat.out_free) begin
                    n_state = (i_stat.item_cmd == CMD_DATA) ? S_DATA : S_FIN_STEP;
                end
            end
            S_FIN_STEP: begin
                if (i_stat.step_last) n_state = S_FIN_OUT;
            end
            S_FIN_OUT: begin
                if (i_stat.out_free && i_stat.step_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.out_sel = OUT_ERR;
        o_cmd.sum_op  = SUM_HOLD;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.latch_in = 1'b1;
            end
            S_DECODE: begin
                o_cmd.step_clr = 1'b1;
            end
            S_ERR: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_ERR;
                    o_cmd.clear    = 1'b1;
                end
            end
            S_HRP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_sel   = OUT_ECHO;
                    o_cmd.hrp_write = 1'b1;
                    o_cmd.sum_op    = SUM_HRP;
                end
            end
            S_SEP_INIT: begin
                o_cmd.sum_op     = SUM_STEP;
                o_cmd.walk_start = 1'b1;
            end
            S_WALK_RD: begin
                o_cmd.walk_rd = !i_stat.walk_done;
            end
            S_WALK_FOLD: begin
                o_cmd.sum_op = SUM_FOLD;
            end
            S_SEP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load       = 1'b1;
                    o_cmd.out_sel        = OUT_SEP;
                    o_cmd.set_data_phase = 1'b1;
                end
            end
            S_DATA: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_DATA;
                    o_cmd.data_inc = 1'b1;
                    o_cmd.sum_op   = SUM_DATA;
                end
            end
            S_FIN_STEP: begin
                // the last zero step also adds the final constant
                o_cmd.sum_op = i_stat.step_last ? SUM_STEP_ONE : SUM_STEP;
                if (i_stat.step_last) o_cmd.step_clr = 1'b1;
                else o_cmd.step_inc = 1'b1;
            end
            S_FIN_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_SUM;
                    o_cmd.sum_op   = SUM_SHIFT;
                    o_cmd.step_inc = 1'b1;
                    o_cmd.clear    = i_stat.step_last;
                end
            end
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

// File: design/bech_dp.sv
`timescale 1ns / 1ps
module bech_dp #(
    parameter int MAX_HRP  = 128,
    parameter int MAX_DATA = 2047
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bech_pkg::t_dp_cmd  i_cmd,
    output bech_pkg::t_dp_stat o_stat,
    input  logic               i_in_valid,
    input  logic [1:0]         i_in_cmd,
    input  logic [6:0]         i_in_value,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [6:0]         o_out_char,
    output logic               o_out_last,
    output logic [2:0]         o_out_status
);
    import bech_pkg::*;

    localparam int HCNT_W = $clog2(MAX_HRP + 1);
    localparam int HRP_AW = (MAX_HRP > 1) ? $clog2(MAX_HRP) : 1;
    localparam int DCNT_W = $clog2(MAX_DATA + 1);
    localparam int LEN_W  = $clog2(MAX_HRP + MAX_DATA + LEN_OVERHEAD + 1);
    localparam logic [HCNT_W-1:0] HRP_LIMIT  = HCNT_W'(MAX_HRP);
    localparam logic [DCNT_W-1:0] DATA_LIMIT = DCNT_W'(MAX_DATA);
    localparam logic [LEN_W-1:0]  LEN_MAX    = LEN_W'(LEN_LIMIT);
    localparam logic [LEN_W-1:0]  LEN_EXTRA  = LEN_W'(LEN_OVERHEAD);

    logic [6:0]        r_hrp_mem [MAX_HRP];
    logic [6:0]        r_rd_data;
    t_cmd              r_item_cmd;
    logic [6:0]        r_item_val;
    logic              r_lightning;
    logic [29:0]       r_sum;
    logic [29:0]       n_sum;
    logic [HCNT_W-1:0] r_hrp_count;
    logic [HCNT_W-1:0] r_idx;
    logic [DCNT_W-1:0] r_data_count;
    logic              r_data_phase;
    logic [2:0]        r_step;
    logic              r_out_valid;
    logic [6:0]        r_out_char;
    logic              r_out_last;
    t_status           r_out_status;

    logic [29:0] sum_step;
    logic [LEN_W-1:0] str_len;
    logic        too_long;
    t_status     item_status;
    logic        out_free;
    logic [6:0]  n_out_char;

    assign sum_step  = poly_step(r_sum);
    assign str_len   = LEN_W'(r_hrp_count) + LEN_W'(r_data_count) + LEN_EXTRA;
    assign too_long  = !r_lightning && (str_len > LEN_MAX);
    assign item_status = item_check(r_item_cmd, r_item_val, r_data_phase,
                                    r_hrp_count >= HRP_LIMIT,
                                    r_data_count >= DATA_LIMIT, too_long);
    assign out_free = !r_out_valid || i_out_ready;

    assign o_stat.item_cmd    = r_item_cmd;
    assign o_stat.item_status = item_status;
    assign o_stat.data_phase  = r_data_phase;
    assign o_stat.walk_done   = r_idx >= r_hrp_count;
    assign o_stat.step_last   = r_step == SUM_LAST_STEP;
    assign o_stat.out_free    = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in && i_in_valid) begin
            r_item_cmd <= t_cmd'(i_in_cmd);
            r_item_val <= i_in_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lightning <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_lightning <= i_cfg_wr_data;
        end
    end

    // hrp buffer: one write port at the fill count, registered read for the walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.hrp_write) begin
            r_hrp_mem[r_hrp_count[HRP_AW-1:0]] <= r_item_val;
        end
        if (i_cmd.walk_rd) begin
            r_rd_data <= r_hrp_mem[r_idx[HRP_AW-1:0]];
        end
    end

    always_comb begin
        n_sum = r_sum;
        unique case (i_cmd.sum_op)
            SUM_HOLD:     n_sum = r_sum;
            SUM_STEP:     n_sum = sum_step;
            SUM_STEP_ONE: n_sum = sum_step ^ SUM_INIT;
            SUM_HRP:      n_sum = sum_step ^ {28'b0, r_item_val[6:5]};
            SUM_DATA:     n_sum = sum_step ^ {25'b0, r_item_val[4:0]};
            SUM_FOLD:     n_sum = sum_step ^ {25'b0, r_rd_data[4:0]};
            SUM_SHIFT:    n_sum = {r_sum[24:0], 5'b0};
            default:      n_sum = r_sum;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_sum        <= SUM_INIT;
            r_hrp_count  <= '0;
            r_data_count <= '0;
            r_data_phase <= 1'b0;
        end else begin
            r_sum <= n_sum;
            if (i_cmd.hrp_write) r_hrp_count <= r_hrp_count + HCNT_W'(1);
            if (i_cmd.data_inc) r_data_count <= r_data_count + DCNT_W'(1);
            if (i_cmd.set_data_phase) r_data_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_step <= '0;
        end else begin
            if (i_cmd.walk_start) r_idx <= '0;
            else if (i_cmd.walk_rd) r_idx <= r_idx + HCNT_W'(1);
            if (i_cmd.step_clr) r_step <= '0;
            else if (i_cmd.step_inc) r_step <= r_step + 3'd1;
        end
    end

    always_comb begin
        unique case (i_cmd.out_sel)
            OUT_ERR:  n_out_char = 7'd0;
            OUT_ECHO: n_out_char = r_item_val;
            OUT_SEP:  n_out_char = SEPARATOR;
            OUT_DATA: n_out_char = alphabet(r_item_val[4:0]);
            OUT_SUM:  n_out_char = alphabet(r_sum[29:25]);
            default:  n_out_char = 7'd0;
        endcase
    end

    // output register: holds one result so the controller can move on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_char   <= n_out_char;
            r_out_last   <= (i_cmd.out_sel == OUT_ERR) ||
                            (i_cmd.out_sel == OUT_SUM && r_step == SUM_LAST_STEP);
            r_out_status <= (i_cmd.out_sel == OUT_ERR) ? item_status : ST_OK;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_out_last   = r_out_last;
    assign o_out_status = r_out_status;

endmodule

// File: design/bech_chk.sv
`timescale 1ns / 1ps
module bech_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_wr_en,
    input logic       i_cfg_wr_data,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic [1:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic [2:0] m_axis_tuser
);
    import bech_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
            $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // an error result carries no character and closes the string
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tlast && m_axis_tdata == 8'd0)
        else $error("malformed error result");

    // one item at a time: no acceptance right after an acceptance
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted in back-to-back cycles");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind bech32_string_encoder_unit bech_chk u_bech_chk (.*);

// File: tb/bech32_string_encoder_unit_tb.sv
`timescale 1ns / 1ps
module bech32_string_encoder_unit_tb;
    import bech_pkg::*;

    localparam int          HRP_DEPTH   = 128;
    localparam int          DATA_DEPTH  = 2047;
    localparam int          MAX_CHARS   = 90;
    localparam logic [6:0]  SEP_CHAR    = 7'h31;
    localparam int unsigned CYCLE_LIMIT = 500000;
    // generator taps, bit b of the top symbol selects slice b
    localparam logic [149:0] BCH_GEN = {30'h2a1462b3, 30'h3d4233dd, 30'h1ea119fa,
                                        30'h26508e6d, 30'h3b6a57b2};
    localparam logic [255:0] SYMBOLS = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    typedef struct packed {
        t_cmd       cmd;
        logic [6:0] value;
        logic       hold;
    } t_send_item;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
        t_status    status;
    } t_char_exp;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic       i_cfg_wr_data = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;  // [6:0] value
    logic [1:0] s_axis_tuser  = 2'd0;   // [1:0] command
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [6:0] character
    logic       m_axis_tlast;
    logic [2:0] m_axis_tuser;           // [2:0] status

    t_send_item  pending_items[$];
    t_send_item  in_flight;
    t_char_exp   expected_chars[$];
    t_char_exp   next_char;
    int          queued_count = 0;
    int          error_count  = 0;
    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;
    int unsigned cycle_count  = 0;

    // encoder state as the block should hold it
    logic [29:0] bch_sum;
    logic [6:0]  hrp_chars [0:HRP_DEPTH-1];
    int          hrp_len;
    int          data_cnt;
    logic        in_data;
    logic        lightning;

    bech32_string_encoder_unit #(
        .MAX_HRP  (HRP_DEPTH),
        .MAX_DATA (DATA_DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    function logic [29:0] bch_step(input logic [29:0] c);
        logic [29:0] r;
        r = {c[24:0], 5'b0};
        for (int b = 0; b < 5; b++) begin
            if (c[25 + b]) r = r ^ BCH_GEN[b * 30 +: 30];
        end
        return r;
    endfunction

    function logic [6:0] symbol_char(input logic [4:0] s);
        return SYMBOLS[(31 - s) * 8 +: 7];
    endfunction

    function void clear_string();
        bch_sum  = 30'd1;
        hrp_len  = 0;
        data_cnt = 0;
        in_data  = 1'b0;
    endfunction

    function void emit_char(input logic [6:0] ch, input logic last, input t_status st);
        t_char_exp e;
        e.ch     = ch;
        e.last   = last;
        e.status = st;
        expected_chars.push_back(e);
    endfunction

    function void fail_string(input t_status st);
        clear_string();
        emit_char(7'd0, 1'b1, st);
    endfunction

    // fold the low bits of the stored hrp, then the separator
    function void open_data();
        bch_sum = bch_step(bch_sum);
        for (int i = 0; i < hrp_len; i++) begin
            bch_sum = bch_step(bch_sum) ^ {25'd0, hrp_chars[i][4:0]};
        end
        in_data = 1'b1;
        emit_char(SEP_CHAR, 1'b0, ST_OK);
    endfunction

    function void encode_item(input t_cmd cmd, input logic [6:0] v);
        case (cmd)
            CMD_HRP: begin
                if (in_data) begin
                    fail_string(ST_HRP_AFTER_DATA);
                end else if (v < 7'd33 || v > 7'd126 || (v >= 7'h41 && v <= 7'h5a)) begin
                    fail_string(ST_BAD_HRP);
                end else if (hrp_len >= HRP_DEPTH) begin
                    fail_string(ST_TOO_LONG);
                end else begin
                    hrp_chars[hrp_len] = v;
                    hrp_len++;
                    bch_sum = bch_step(bch_sum) ^ {28'd0, v[6:5]};
                    emit_char(v, 1'b0, ST_OK);
                end
            end
            CMD_DATA: begin
                if (v > 7'd31) begin
                    fail_string(ST_BAD_DATA);
                end else if (data_cnt >= DATA_DEPTH) begin
                    fail_string(ST_TOO_LONG);
                end else begin
                    if (!in_data) open_data();
                    bch_sum = bch_step(bch_sum) ^ {25'd0, v[4:0]};
                    data_cnt++;
                    emit_char(symbol_char(v[4:0]), 1'b0, ST_OK);
                end
            end
            CMD_FINISH: begin
                if (!lightning && hrp_len + 7 + data_cnt > MAX_CHARS) begin
                    fail_string(ST_TOO_LONG);
                end else begin
                    if (!in_data) open_data();
                    for (int i = 0; i < 6; i++) bch_sum = bch_step(bch_sum);
                    bch_sum = bch_sum ^ 30'd1;
                    for (int i = 0; i < 6; i++) begin
                        emit_char(symbol_char(bch_sum[(5 - i) * 5 +: 5]), i == 5, ST_OK);
                    end
                    clear_string();
                end
            end
            default: ;
        endcase
    endfunction

    task report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
        error_count++;
        $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    function void queue_item(input t_cmd cmd, input logic [6:0] v, input logic hold = 1'b0);
        t_send_item it;
        it.cmd   = cmd;
        it.value = v;
        it.hold  = hold;
        pending_items.push_back(it);
        if (cmd != CMD_NONE) queued_count++;
    endfunction

    function logic [6:0] rand_hrp_char();
        logic [6:0] c;
        do begin
            c = 7'($urandom_range(126, 33));
        end while (c >= 7'h41 && c <= 7'h5a);
        return c;
    endfunction

    function void queue_hrp_run(input int n);
        for (int i = 0; i < n; i++) queue_item(CMD_HRP, rand_hrp_char());
    endfunction

    function void queue_noise();
        case ($urandom_range(4))
            0: begin
                case ($urandom_range(2))
                    0:       queue_item(CMD_HRP, 7'($urandom_range(32)));
                    1:       queue_item(CMD_HRP, 7'd127);
                    default: queue_item(CMD_HRP, 7'($urandom_range(90, 65)));
                endcase
            end
            1:       queue_item(CMD_DATA, 7'($urandom_range(127, 32)));
            2:       queue_item(CMD_HRP, rand_hrp_char());
            3:       queue_item(CMD_NONE, 7'($urandom_range(127)));
            default: queue_item(CMD_FINISH, 7'($urandom_range(127)));
        endcase
    endfunction

    // mostly well-formed strings; now and then a stray item or a missing finish
    function void queue_random_string();
        int   n_hrp;
        int   n_data;
        int   total;
        int   noise_at;
        logic hold_first;
        logic hold_here;
        n_hrp      = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
        n_data     = ($urandom_range(9) == 0) ? $urandom_range(100, 75) : $urandom_range(20);
        total      = n_hrp + n_data;
        noise_at   = ($urandom_range(7) == 0) ? $urandom_range(total) : -1;
        hold_first = ($urandom_range(5) == 0);
        for (int i = 0; i <= total; i++) begin
            hold_here = (i == 0) && hold_first;
            if (i == noise_at) queue_noise();
            if (i < n_hrp) begin
                queue_item(CMD_HRP, rand_hrp_char(), hold_here);
            end else if (i < total) begin
                queue_item(CMD_DATA, 7'($urandom_range(31)), hold_here);
            end else if ($urandom_range(19) != 0) begin
                queue_item(CMD_FINISH, 7'($urandom_range(127)), hold_here);
            end
        end
    endfunction

    task wait_drained(input int settle);
        do begin
            @(negedge i_clk);
        end while (pending_items.size() != 0 || s_axis_tvalid || expected_chars.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task write_lightning(input logic v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        lightning = v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // driver: predict on acceptance, then offer the next item or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                encode_item(in_flight.cmd, in_flight.value);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() != 0 &&
                    !(pending_items[0].hold && expected_chars.size() != 0) &&
                    $urandom_range(99) >= src_idle_pct) begin
                    in_flight = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {1'b0, in_flight.value};
                    s_axis_tuser  <= in_flight.cmd;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("unexpected item", m_axis_tdata, 8'h00);
                end else begin
                    next_char = expected_chars.pop_front();
                    if (m_axis_tdata !== {1'b0, next_char.ch})
                        report_mismatch("character", m_axis_tdata, {1'b0, next_char.ch});
                    if (m_axis_tlast !== next_char.last)
                        report_mismatch("last", {7'd0, m_axis_tlast},
                                        {7'd0, next_char.last});
                    if (m_axis_tuser !== next_char.status)
                        report_mismatch("status", {5'd0, m_axis_tuser},
                                        {5'd0, next_char.status});
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        clear_string();
        lightning = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n       <= 1'b1;
        src_idle_pct  <= 36;
        sink_idle_pct <= 78;
        write_lightning(1'b0);

        // field extremes, then bad hrp, bad data and hrp-after-data errors
        queue_item(CMD_HRP, 7'h21);
        queue_item(CMD_HRP, 7'h7e);
        queue_item(CMD_HRP, 7'h40);
        queue_item(CMD_HRP, 7'h5b);
        queue_item(CMD_DATA, 7'd0);
        queue_item(CMD_DATA, 7'd31);
        queue_item(CMD_FINISH, 7'd127);
        queue_item(CMD_FINISH, 7'd0, 1'b1); // empty hrp, no data
        queue_item(CMD_DATA, 7'd5);
        queue_item(CMD_FINISH, 7'd0);
        queue_item(CMD_HRP, 7'd32);
        queue_item(CMD_HRP, 7'd127);
        queue_item(CMD_HRP, 7'h41);
        queue_item(CMD_HRP, 7'h5a);
        queue_item(CMD_HRP, 7'd0);
        queue_item(CMD_DATA, 7'd32);        // bad data before any separator
        queue_item(CMD_HRP, 7'h62);
        queue_item(CMD_DATA, 7'd1);
        queue_item(CMD_DATA, 7'd127);
        queue_item(CMD_HRP, 7'h63);
        queue_item(CMD_DATA, 7'd2);
        queue_item(CMD_HRP, 7'h64);         // hrp once data has begun
        queue_item(CMD_NONE, 7'd127);
        queue_item(CMD_HRP, 7'h65);
        queue_item(CMD_NONE, 7'd0);
        queue_item(CMD_FINISH, 7'd0);

        queued_count = 0;
        while (queued_count < 35) queue_random_string();
        wait_drained(20);

        src_idle_pct  <= 78;
        sink_idle_pct <= 36;
        write_lightning(1'b1);
        // full hrp buffer walked, then one past it
        queue_hrp_run(HRP_DEPTH);
        queue_item(CMD_DATA, 7'd31);
        queue_item(CMD_FINISH, 7'd0);
        queue_hrp_run(HRP_DEPTH + 1);
        queued_count = 0;
        while (queued_count < 35) queue_random_string();
        wait_drained(20);

        src_idle_pct  <= 0;
        sink_idle_pct <= 0;
        write_lightning(1'b0);
        queued_count = 0;
        while (queued_count < 35) queue_random_string();
        wait_drained(50);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
design/bech_pkg.sv
design/bech_ctrl.sv
design/bech_dp.sv
design/bech32_string_encoder_unit.sv
design/bech_chk.sv
tb/bech32_string_encoder_unit_tb.sv
